FILE: design/igsf_pkg.sv
// Shared constants, types and the shade table of the glitch smoothing filter.
`timescale 1ns / 1ps
package igsf_pkg;

  localparam int MAX_COLS    = 32;
  localparam int MAX_ROWS    = 1024;
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int LEVEL_W     = 4;
  localparam int SHADE_W     = 7;
  localparam int ROWS_CFG_W  = 11;
  localparam int COLS_CFG_W  = 6;
  localparam int THR_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int NUM_BUFS    = 3;
  localparam int BUF_W       = 2;
  localparam int STORE_DEPTH = NUM_BUFS * MAX_COLS;
  localparam int STORE_AW    = BUF_W + COL_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(9);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS   = 2'd0,
    CFG_COLS   = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ROWS_CFG_W-1:0] image_rows;
    logic [COLS_CFG_W-1:0] image_cols;
    logic [THR_W-1:0]      diff_threshold;
  } cfg_t;

  // Everything the back end needs to produce the results of one input item.
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [LEVEL_W-1:0] pix;
    logic [LEVEL_W-1:0] up_pp;
    logic [LEVEL_W-1:0] prev_c;
    logic [LEVEL_W-1:0] prev_m1;
    logic [LEVEL_W-1:0] prev_p1;
    logic [LEVEL_W-1:0] cur_m1;
    logic [LEVEL_W-1:0] cur_m2;
    logic               has_mid;
    logic               has_lr;
    logic               has_fe;
    logic               r_ge2;
    logic               c_ge1;
    logic               c_ge2;
    logic               right_ok;
  } task_t;

  typedef struct packed {
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic [LEVEL_W-1:0] smoothed_level;
    logic [SHADE_W-1:0] shade_char;
    logic               was_replaced;
    logic               last_of_run;
    logic               end_of_frame;
  } res_t;

  function automatic logic [SHADE_W-1:0] shade_of(input logic [LEVEL_W-1:0] lvl);
    logic [SHADE_W-1:0] ch;
    case (lvl)
      4'd0:    ch = 7'd32;   // space
      4'd1:    ch = 7'd46;   // .
      4'd2:    ch = 7'd94;   // ^
      4'd3:    ch = 7'd58;   // :
      4'd4:    ch = 7'd126;  // ~
      4'd5:    ch = 7'd42;   // *
      4'd6:    ch = 7'd61;   // =
      4'd7:    ch = 7'd43;   // +
      4'd8:    ch = 7'd37;   // %
      default: ch = 7'd35;   // #
    endcase
    return ch;
  endfunction

endpackage

FILE: design/igsf_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
module igsf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

FILE: design/igsf_front.sv
// Front end: accepts pixels, tracks position, owns the row store and builds tasks.
`timescale 1ns / 1ps
module igsf_front import igsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              push,
  input  logic [LEVEL_W-1:0] pixel_level,
  output logic              full,
  input  logic [QLVL_W-1:0] q_level,
  output logic              task_valid,
  output task_t             task_out
);

  logic [ROW_W-1:0]      row_count;
  logic [COL_W-1:0]      col_count;
  logic [BUF_W-1:0]      store_rotation;
  logic [LEVEL_W-1:0]    cur_m1;
  logic [LEVEL_W-1:0]    cur_m2;
  logic [LEVEL_W-1:0]    win0;
  logic [LEVEL_W-1:0]    win1;
  logic                  s1_valid;
  task_t                 s1;

  logic [ROWS_CFG_W-1:0] rows_eff;
  logic [COLS_CFG_W-1:0] cols_eff;
  logic                  last_row;
  logic                  last_col;
  logic                  accept;
  logic [LEVEL_W-1:0]    pix_sat;
  logic [BUF_W-1:0]      prev_buf;
  logic [BUF_W-1:0]      pp_buf;
  logic [STORE_AW-1:0]   wr_addr;
  logic [STORE_AW-1:0]   rd_addr_a;
  logic [STORE_AW-1:0]   rd_addr_b;
  logic [LEVEL_W-1:0]    rd_data_a;
  logic [LEVEL_W-1:0]    rd_data_b;

  always_comb begin
    if (cfg.image_rows < ROWS_CFG_W'(2)) begin
      rows_eff = ROWS_CFG_W'(2);
    end else if (cfg.image_rows > ROWS_CFG_W'(MAX_ROWS)) begin
      rows_eff = ROWS_CFG_W'(MAX_ROWS);
    end else begin
      rows_eff = cfg.image_rows;
    end
    if (cfg.image_cols < COLS_CFG_W'(2)) begin
      cols_eff = COLS_CFG_W'(2);
    end else if (cfg.image_cols > COLS_CFG_W'(MAX_COLS)) begin
      cols_eff = COLS_CFG_W'(MAX_COLS);
    end else begin
      cols_eff = cfg.image_cols;
    end
  end

  assign last_row = (ROWS_CFG_W'(row_count) + ROWS_CFG_W'(1)) >= rows_eff;
  assign last_col = (COLS_CFG_W'(col_count) + COLS_CFG_W'(1)) >= cols_eff;
  assign pix_sat  = (pixel_level > MAX_LEVEL) ? MAX_LEVEL : pixel_level;

  // Every task in flight in the read stage needs a queue slot.
  assign full   = (q_level + QLVL_W'(s1_valid)) >= QLVL_W'(QUEUE_DEPTH);
  assign accept = push && !full;

  always_comb begin
    case (store_rotation)
      2'd0:    begin prev_buf = 2'd2; pp_buf = 2'd1; end
      2'd1:    begin prev_buf = 2'd0; pp_buf = 2'd2; end
      default: begin prev_buf = 2'd1; pp_buf = 2'd0; end
    endcase
  end

  // At the end of a row, port A fetches column 0 of the row just finished, which is
  // the centre of the first pixel emitted on the next row.
  assign wr_addr   = {store_rotation, col_count};
  assign rd_addr_a = last_col ? {store_rotation, COL_W'(0)}
                              : {prev_buf, col_count + COL_W'(1)};
  assign rd_addr_b = {pp_buf, col_count};

  igsf_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (wr_addr),
    .wr_data   (pix_sat),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= '0;
      col_count      <= '0;
      store_rotation <= '0;
      s1_valid       <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_col) begin
          col_count <= '0;
          if (last_row) begin
            row_count      <= '0;
            store_rotation <= '0;
          end else begin
            row_count      <= row_count + ROW_W'(1);
            store_rotation <= (store_rotation == BUF_W'(NUM_BUFS - 1)) ? '0
                              : store_rotation + BUF_W'(1);
          end
        end else begin
          col_count <= col_count + COL_W'(1);
        end
      end
    end
    if (accept) begin
      cur_m2      <= cur_m1;
      cur_m1      <= pix_sat;
      s1.row      <= row_count;
      s1.col      <= col_count;
      s1.pix      <= pix_sat;
      s1.cur_m1   <= cur_m1;
      s1.cur_m2   <= cur_m2;
      s1.has_mid  <= row_count != '0;
      s1.has_lr   <= last_row && (col_count != '0);
      s1.has_fe   <= last_row && last_col;
      s1.r_ge2    <= row_count >= ROW_W'(2);
      s1.c_ge1    <= col_count != '0;
      s1.c_ge2    <= col_count >= COL_W'(2);
      s1.right_ok <= (COLS_CFG_W'(col_count) + COLS_CFG_W'(1)) < cols_eff;
      s1.up_pp    <= '0;
      s1.prev_c   <= '0;
      s1.prev_m1  <= '0;
      s1.prev_p1  <= '0;
    end
    // The previous-row window slides one column per task.
    if (s1_valid) begin
      win1 <= win0;
      win0 <= rd_data_a;
    end
  end

  always_comb begin
    task_out         = s1;
    task_out.up_pp   = rd_data_b;
    task_out.prev_c  = win0;
    task_out.prev_m1 = win1;
    task_out.prev_p1 = rd_data_a;
  end

  assign task_valid = s1_valid;

endmodule

FILE: design/igsf_queue.sv
// Short task queue between the front and back ends.
`timescale 1ns / 1ps
module igsf_queue import igsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_en,
  input  task_t             push_task,
  input  logic              pop_en,
  output logic              head_valid,
  output task_t             head_task,
  output logic [QLVL_W-1:0] level
);

  task_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;

  assign head_valid = level != '0;
  assign head_task  = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      if (push_en) begin
        tail <= tail + QPTR_W'(1);
      end
      if (pop_en) begin
        head <= head + QPTR_W'(1);
      end
      if (push_en && !pop_en) begin
        level <= level + QLVL_W'(1);
      end else if (pop_en && !push_en) begin
        level <= level - QLVL_W'(1);
      end
    end
    if (push_en) begin
      slots[tail] <= push_task;
    end
  end

endmodule

FILE: design/igsf_back.sv
// Back end: judges each pixel against its neighbours and emits one result a cycle while results are popped.
`timescale 1ns / 1ps
module igsf_back import igsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [THR_W-1:0]  diff_threshold,
  input  logic              q_valid,
  input  task_t             q_task,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output res_t              res
);

  localparam logic [2:0] PH_MID = 3'b001;
  localparam logic [2:0] PH_LR  = 3'b010;

  logic               out_valid;
  logic [2:0]         done;
  logic [2:0]         pend;
  logic [2:0]         sel;
  logic [2:0]         rest;
  logic               slot_free;
  logic               emit;

  logic [LEVEL_W-1:0] ctr;
  logic [LEVEL_W-1:0] nb [4];
  logic [3:0]         ok;
  logic [ROW_W-1:0]   row_sel;
  logic [COL_W-1:0]   col_sel;
  logic [2:0]         n;
  logic [5:0]         sum;
  logic               all_far;
  logic [LEVEL_W-1:0] diff;
  logic [11:0]        prod3;
  logic [LEVEL_W-1:0] avg;
  logic               rep;
  logic [LEVEL_W-1:0] lvl;

  assign pend      = {q_task.has_fe, q_task.has_lr, q_task.has_mid} & ~done;
  assign sel       = pend & (~pend + 3'd1);
  assign rest      = pend & ~sel;
  assign slot_free = !out_valid || pop;
  assign emit      = q_valid && (pend != '0) && slot_free;
  // A task with no results left is dropped; otherwise it leaves with its last result.
  assign q_pop     = q_valid && ((pend == '0) || (slot_free && (rest == '0)));
  assign empty     = !out_valid;

  always_comb begin
    case (sel)
      PH_MID: begin
        row_sel = q_task.row - ROW_W'(1);
        col_sel = q_task.col;
        ctr     = q_task.prev_c;
        nb[0] = q_task.up_pp;   ok[0] = q_task.r_ge2;
        nb[1] = q_task.pix;     ok[1] = 1'b1;
        nb[2] = q_task.prev_m1; ok[2] = q_task.c_ge1;
        nb[3] = q_task.prev_p1; ok[3] = q_task.right_ok;
      end
      PH_LR: begin
        row_sel = q_task.row;
        col_sel = q_task.col - COL_W'(1);
        ctr     = q_task.cur_m1;
        nb[0] = q_task.prev_m1; ok[0] = q_task.has_mid;
        nb[1] = '0;             ok[1] = 1'b0;
        nb[2] = q_task.cur_m2;  ok[2] = q_task.c_ge2;
        nb[3] = q_task.pix;     ok[3] = 1'b1;
      end
      default: begin
        row_sel = q_task.row;
        col_sel = q_task.col;
        ctr     = q_task.pix;
        nb[0] = q_task.prev_c;  ok[0] = q_task.has_mid;
        nb[1] = '0;             ok[1] = 1'b0;
        nb[2] = q_task.cur_m1;  ok[2] = q_task.c_ge1;
        nb[3] = '0;             ok[3] = 1'b0;
      end
    endcase
  end

  always_comb begin
    n       = '0;
    sum     = '0;
    all_far = 1'b1;
    diff    = '0;
    for (int k = 0; k < 4; k++) begin
      diff = (ctr > nb[k]) ? ctr - nb[k] : nb[k] - ctr;
      if (ok[k]) begin
        n   = n + 3'd1;
        sum = sum + 6'(nb[k]);
        if (diff <= diff_threshold) begin
          all_far = 1'b0;
        end
      end
    end
    // Division by three as a multiply by 43/128, exact for sums this small.
    prod3 = 12'(sum) * 12'd43;
    case (n)
      3'd1:    avg = sum[LEVEL_W-1:0];
      3'd2:    avg = sum[LEVEL_W:1];
      3'd3:    avg = prod3[10:7];
      default: avg = sum[LEVEL_W+1:2];
    endcase
    rep = all_far && (n != '0);
    lvl = rep ? avg : ctr;
    if (lvl > MAX_LEVEL) begin
      lvl = MAX_LEVEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        done <= '0;
      end else if (emit) begin
        done <= done | sel;
      end
    end
    if (emit) begin
      res.out_row        <= row_sel;
      res.out_col        <= col_sel;
      res.smoothed_level <= lvl;
      res.shade_char     <= shade_of(lvl);
      res.was_replaced   <= rep;
      res.last_of_run    <= rest == '0;
      res.end_of_frame   <= (sel != PH_MID) && (sel != PH_LR);
    end
  end

endmodule

FILE: design/image_glitch_smoothing_filter.sv
// Top level of the image glitch smoothing filter: configuration, front, queue and back.
`timescale 1ns / 1ps
// The filter takes a raster-scanned grey image of levels 0 to 9, one pixel per item,
// and replaces a pixel by the truncated average of its up, down, left and right
// neighbours (only those inside the frame) when it differs by more than the threshold
// from every one of them. Levels above 9 are read as 9. Results lag the input by one
// row: pixels of the first row give no result, each pixel of a middle row releases the
// pixel above it, and each pixel of the last row also releases its left neighbour, the
// frame's final pixel releasing itself as a third result. Input and output behave as
// queues. In the middle rows one pixel is taken every clock while results are popped;
// the result side delivers one item per clock, so on the last row, where most pixels
// yield two results, the input is held back and full is raised as the four-entry task
// queue fills. A pixel's task passes from the read stage through the task queue to the
// result register of the back end. The front end holds three rows of 32 levels in a RAM
// with one write and two registered read ports, read once per pixel; its contents are not
// cleared after reset, so the block accepts pixels from the first cycle out of reset.
// Registers (image_rows, image_cols, diff_threshold at indices 0, 1 and 2) are written
// through the cfg port, which is always ready, and must only be changed while the block
// is idle. Rows and columns are clamped to 2..1024 and 2..32.
module image_glitch_smoothing_filter import igsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [LEVEL_W-1:0]    pixel_level,
  output logic                  empty,
  input  logic                  pop,
  output logic [ROW_W-1:0]      out_row,
  output logic [COL_W-1:0]      out_col,
  output logic [LEVEL_W-1:0]    smoothed_level,
  output logic [SHADE_W-1:0]    shade_char,
  output logic                  was_replaced,
  output logic                  last_of_run,
  output logic                  end_of_frame,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic              task_valid;
  task_t             task_front;
  logic              q_valid;
  task_t             q_task;
  logic              q_pop;
  logic [QLVL_W-1:0] q_level;
  res_t              res;

  // Configuration writes go straight into the registers, so the channel never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_rows     <= ROWS_CFG_W'(20);
      cfg.image_cols     <= COLS_CFG_W'(30);
      cfg.diff_threshold <= THR_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROWS:   cfg.image_rows     <= cfg_data[ROWS_CFG_W-1:0];
        CFG_COLS:   cfg.image_cols     <= cfg_data[COLS_CFG_W-1:0];
        CFG_THRESH: cfg.diff_threshold <= cfg_data[THR_W-1:0];
        default:    ;  // unused index: write is dropped
      endcase
    end
  end

  igsf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .pixel_level (pixel_level),
    .full        (full),
    .q_level     (q_level),
    .task_valid  (task_valid),
    .task_out    (task_front)
  );

  igsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_en    (task_valid),
    .push_task  (task_front),
    .pop_en     (q_pop),
    .head_valid (q_valid),
    .head_task  (q_task),
    .level      (q_level)
  );

  igsf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .diff_threshold (cfg.diff_threshold),
    .q_valid        (q_valid),
    .q_task         (q_task),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .res            (res)
  );

  assign out_row        = res.out_row;
  assign out_col        = res.out_col;
  assign smoothed_level = res.smoothed_level;
  assign shade_char     = res.shade_char;
  assign was_replaced   = res.was_replaced;
  assign last_of_run    = res.last_of_run;
  assign end_of_frame   = res.end_of_frame;

endmodule
